>>> hdl/bcc_pkg.sv
// ---------------------------------------------------------------------------
// bcc_pkg
// Shared constants and types for the button click classifier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_LONG_PRESS   = 2'd1,
        REG_DOUBLE_CLICK = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;

    // Packed highest bit first: pressed in bit 0
    typedef struct packed {
        logic clicked;
        logic double_clicked;
        logic long_pressed;
        logic released;
        logic pressed;
    } bcc_events_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] double_click_ticks;
    } bcc_cfg_t;

endpackage

>>> hdl/bcc_core.sv
// ---------------------------------------------------------------------------
// bcc_core
// Tick counter, debounce and click state; derives the events of one tick.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_core
    import bcc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        pin_level,
    input  bcc_cfg_t    cfg,
    output bcc_events_t events
);

    logic [TIME_BITS-1:0] tick_reg,         tick_next;
    logic [TIME_BITS-1:0] last_change_reg,  last_change_next;
    logic [TIME_BITS-1:0] press_start_reg,  press_start_next;
    logic [TIME_BITS-1:0] first_rel_reg,    first_rel_next;
    logic                 prev_level_reg,   prev_level_next;
    logic                 pending_reg,      pending_next;

    logic [TIME_BITS-1:0] since_change;
    logic [TIME_BITS-1:0] held_for;
    logic [TIME_BITS-1:0] since_first;
    logic                 change_ok;
    logic                 press_ev;
    logic                 release_ev;
    logic                 is_long;
    logic                 short_rel;
    logic                 in_window;
    logic                 dbl_ev;
    logic                 late_ev;
    logic                 timeout_ev;

    // Differences wrap naturally at TIME_BITS
    assign since_change = tick_reg - last_change_reg;
    assign held_for     = tick_reg - press_start_reg;
    assign since_first  = tick_reg - first_rel_reg;

    assign change_ok  = (pin_level != prev_level_reg)
                        && (since_change >= TIME_BITS'(cfg.debounce_ticks));
    assign press_ev   = change_ok && !pin_level;
    assign release_ev = change_ok && pin_level;
    assign is_long    = held_for >= TIME_BITS'(cfg.long_press_ticks);
    assign short_rel  = release_ev && !is_long;
    assign in_window  = since_first <= TIME_BITS'(cfg.double_click_ticks);
    assign dbl_ev     = short_rel && pending_reg && in_window;
    assign late_ev    = short_rel && pending_reg && !in_window;
    // A short release always leaves a fresh or cleared window, so no expiry then
    assign timeout_ev = !short_rel && pending_reg && !in_window;

    always_comb
    begin
        events.pressed        = press_ev;
        events.released       = release_ev;
        events.long_pressed   = release_ev && is_long;
        events.double_clicked = dbl_ev;
        events.clicked        = late_ev || timeout_ev;
    end

    always_comb
    begin
        tick_next        = tick_reg;
        last_change_next = last_change_reg;
        press_start_next = press_start_reg;
        first_rel_next   = first_rel_reg;
        prev_level_next  = prev_level_reg;
        pending_next     = pending_reg;
        if (step)
        begin
            tick_next       = tick_reg + TIME_BITS'(1);
            prev_level_next = pin_level;
            if (change_ok)
            begin
                last_change_next = tick_reg;
            end
            if (press_ev)
            begin
                press_start_next = tick_reg;
            end
            if (short_rel)
            begin
                pending_next = !dbl_ev;
                if (!dbl_ev)
                begin
                    first_rel_next = tick_reg;
                end
            end
            else if (timeout_ev)
            begin
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            last_change_reg <= '0;
            press_start_reg <= '0;
            first_rel_reg   <= '0;
            prev_level_reg  <= 1'b1;
            pending_reg     <= 1'b0;
        end
        else
        begin
            tick_reg        <= tick_next;
            last_change_reg <= last_change_next;
            press_start_reg <= press_start_next;
            first_rel_reg   <= first_rel_next;
            prev_level_reg  <= prev_level_next;
            pending_reg     <= pending_next;
        end
    end

`ifndef SYNTHESIS
    a_dbl_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && dbl_ev |=> !pending_reg)
        else $error("double click left a click pending");

    a_short_rel_opens: assert property (@(posedge clk) disable iff (!rst_n)
        step && short_rel && !dbl_ev |=> pending_reg && (first_rel_reg == $past(tick_reg)))
        else $error("short release did not open a window");

    a_click_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        events.clicked || events.double_clicked |-> pending_reg)
        else $error("click reported with nothing pending");
`endif

endmodule

>>> hdl/button_click_classifier.sv
// ---------------------------------------------------------------------------
// button_click_classifier
// Debounces an active-low button sample stream and reports click events.
// ---------------------------------------------------------------------------
// Each input transfer is one time tick carrying the sampled pin level (0 =
// pressed); each tick yields exactly one result transfer with the flags
// pressed, released, long_pressed, double_clicked and clicked. The block takes
// one tick per clock cycle unless the output stalls; its result reaches the
// output register in the next cycle, and a new tick is taken even while that
// result waits, as long as it is taken in the same cycle. The cycle time is
// set by the TIME_BITS-wide subtract-and-compare of the elapsed-time checks.
// Write the thresholds through the configuration channel only while idle.
`timescale 1ns / 1ps

module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] pin_level
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] pressed, [1] released,
                                                  // [2] long_pressed,
                                                  // [3] double_clicked, [4] clicked
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    bcc_cfg_t    cfg_reg;
    bcc_events_t events;
    bcc_events_t out_data_reg;
    logic        out_valid_reg, out_valid_next;
    logic        in_xfer;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks     <= DEBOUNCE_RST;
            cfg_reg.long_press_ticks   <= LONG_PRESS_RST;
            cfg_reg.double_click_ticks <= DOUBLE_CLICK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE:     cfg_reg.debounce_ticks     <= cfg_data;
                REG_LONG_PRESS:   cfg_reg.long_press_ticks   <= cfg_data;
                REG_DOUBLE_CLICK: cfg_reg.double_click_ticks <= cfg_data;
                default:          ; // drop writes to unused indices
            endcase
        end
    end

    bcc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_xfer),
        .pin_level (s_axis_tdata[0]),
        .cfg       (cfg_reg),
        .events    (events)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until the downstream transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= events;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_data_reg);

`ifndef SYNTHESIS
    a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_data_reg.pressed && out_data_reg.released))
        else $error("press and release in one tick");

    a_release_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_data_reg.long_pressed || out_data_reg.double_clicked)
        |-> out_data_reg.released)
        else $error("long press or double click without release");

    a_long_dbl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_data_reg.long_pressed && out_data_reg.double_clicked))
        else $error("long press and double click together");
`endif

endmodule
